/* rtl/core/sbfc_pkg.sv */
// shared types and constants of the sprite blitter
`timescale 1ns / 1ps
package sbfc_pkg;

  // request kinds carried in s_axis_tuser
  localparam logic REQ_CMD   = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 64;

  // input word field positions
  localparam int unsigned PX_LO  = 0;
  localparam int unsigned PY_LO  = 11;
  localparam int unsigned SW_LO  = 22;
  localparam int unsigned SH_LO  = 32;
  localparam int unsigned SC_LO  = 42;
  localparam int unsigned SR_LO  = 54;
  localparam int unsigned ST_LO  = 66;
  localparam int unsigned FL_LO  = 78;
  localparam int unsigned KEY_LO = 81;
  localparam int unsigned PIX_LO = 97;

  // flip bits
  localparam int unsigned FLIP_H = 0;
  localparam int unsigned FLIP_V = 1;
  localparam int unsigned FLIP_D = 2;

  // one classified item on its way from front to back
  typedef struct packed {
    logic        has_fetch;
    logic [9:0]  off_x;
    logic [9:0]  off_y;
    logic [11:0] base_col;
    logic [11:0] base_row;
    logic [11:0] stride;
    logic [2:0]  flips;
    logic [9:0]  size_w;
    logic [9:0]  size_h;
    logic        on;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [15:0] color;
    logic        wr;
    logic        done;
  } sbfc_rec_t;

endpackage

/* rtl/core/sbfc_front.sv */
// front end: takes words, tracks the blit walk and classifies each word
`timescale 1ns / 1ps
module sbfc_front #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbfc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           full_i,
  output logic                           push_o,
  output sbfc_pkg::sbfc_rec_t            rec_o
);

  logic        active_q, active_d;
  logic [9:0]  col_q, col_d, row_q, row_d;
  logic [10:0] org_x_q, org_x_d, org_y_q, org_y_d;
  logic [9:0]  size_w_q, size_w_d, size_h_q, size_h_d;
  logic [11:0] base_col_q, base_col_d, base_row_q, base_row_d, stride_q, stride_d;
  logic [2:0]  flips_q, flips_d;
  logic [15:0] key_q, key_d;

  logic [10:0] in_px, in_py;
  logic [9:0]  in_sw, in_sh;
  logic [15:0] in_pix;
  logic [11:0] cx, cy;
  logic [10:0] col_inc, row_inc;
  logic        col_wrap, last, on;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  assign in_px  = s_axis_tdata[sbfc_pkg::PX_LO +: 11];
  assign in_py  = s_axis_tdata[sbfc_pkg::PY_LO +: 11];
  assign in_sw  = s_axis_tdata[sbfc_pkg::SW_LO +: 10];
  assign in_sh  = s_axis_tdata[sbfc_pkg::SH_LO +: 10];
  assign in_pix = s_axis_tdata[sbfc_pkg::PIX_LO +: 16];

  assign cx       = {org_x_q[10], org_x_q} + {2'b00, col_q};
  assign cy       = {org_y_q[10], org_y_q} + {2'b00, row_q};
  assign on       = !cx[11] && (cx < 12'(SCREEN_WIDTH)) &&
                    !cy[11] && (cy < 12'(SCREEN_HEIGHT));
  assign col_inc  = {1'b0, col_q} + 11'd1;
  assign row_inc  = {1'b0, row_q} + 11'd1;
  assign col_wrap = col_inc >= {1'b0, size_w_q};
  assign last     = col_wrap && (row_inc >= {1'b0, size_h_q});

  always_comb begin
    active_d   = active_q;
    col_d      = col_q;
    row_d      = row_q;
    org_x_d    = org_x_q;
    org_y_d    = org_y_q;
    size_w_d   = size_w_q;
    size_h_d   = size_h_q;
    base_col_d = base_col_q;
    base_row_d = base_row_q;
    stride_d   = stride_q;
    flips_d    = flips_q;
    key_d      = key_q;
    rec_o      = '0;
    if (s_axis_tuser == sbfc_pkg::REQ_CMD) begin
      org_x_d    = in_px;
      org_y_d    = in_py;
      size_w_d   = in_sw;
      size_h_d   = in_sh;
      base_col_d = s_axis_tdata[sbfc_pkg::SC_LO +: 12];
      base_row_d = s_axis_tdata[sbfc_pkg::SR_LO +: 12];
      stride_d   = s_axis_tdata[sbfc_pkg::ST_LO +: 12];
      flips_d    = s_axis_tdata[sbfc_pkg::FL_LO +: 3];
      key_d      = s_axis_tdata[sbfc_pkg::KEY_LO +: 16];
      col_d      = '0;
      row_d      = '0;
      active_d   = (in_sw != '0) && (in_sh != '0);
      rec_o.has_fetch = active_d;
      rec_o.done      = !active_d;
    end else if (active_q) begin
      rec_o.on    = on;
      rec_o.cx    = cx[9:0];
      rec_o.cy    = cy[9:0];
      rec_o.color = in_pix;
      rec_o.wr    = on && (in_pix != key_q);
      rec_o.done  = last;
      if (last) begin
        active_d = 1'b0;
        col_d    = '0;
        row_d    = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_inc[9:0];
      end else begin
        col_d = col_inc[9:0];
      end
      rec_o.has_fetch = !last;
    end
    rec_o.off_x    = col_d;
    rec_o.off_y    = row_d;
    rec_o.base_col = base_col_d;
    rec_o.base_row = base_row_d;
    rec_o.stride   = stride_d;
    rec_o.flips    = flips_d;
    rec_o.size_w   = size_w_d;
    rec_o.size_h   = size_h_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      size_w_q   <= '0;
      size_h_q   <= '0;
      base_col_q <= '0;
      base_row_q <= '0;
      stride_q   <= '0;
      flips_q    <= '0;
      key_q      <= '0;
    end else if (push_o) begin
      active_q   <= active_d;
      col_q      <= col_d;
      row_q      <= row_d;
      org_x_q    <= org_x_d;
      org_y_q    <= org_y_d;
      size_w_q   <= size_w_d;
      size_h_q   <= size_h_d;
      base_col_q <= base_col_d;
      base_row_q <= base_row_d;
      stride_q   <= stride_d;
      flips_q    <= flips_d;
      key_q      <= key_d;
    end
  end

endmodule

/* rtl/core/sbfc_fifo.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
module sbfc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sbfc_pkg::sbfc_rec_t data_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output sbfc_pkg::sbfc_rec_t data_o
);

  sbfc_pkg::sbfc_rec_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/sbfc_back.sv */
// back end: sheet address and frame index pipeline with output register
`timescale 1ns / 1ps
module sbfc_back #(
  parameter int unsigned SCREEN_WIDTH = 320
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  sbfc_pkg::sbfc_rec_t             rec_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sbfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic        a_v_q;
  logic [23:0] a_px_q, a_py_q;
  logic [11:0] a_stride_q;
  logic        a_fetch_q, a_on_q, a_wr_q, a_done_q;
  logic [9:0]  a_cx_q, a_cy_q;
  logic [15:0] a_color_q;

  logic        out_v_q;
  logic [23:0] out_addr_q;
  logic [16:0] out_fidx_q;
  logic [15:0] out_color_q;
  logic        out_wr_q, out_done_q;

  logic        out_ready, a_ready;
  logic [9:0]  sx, sy, dx, dy;
  logic [23:0] px_d, py_d;
  logic [35:0] prod;
  logic [23:0] addr_d;
  logic [19:0] fidx_d;

  assign out_ready = !out_v_q || m_axis_tready;
  assign a_ready   = !a_v_q || out_ready;
  assign pop_o     = valid_i && a_ready;

  always_comb begin
    sx   = rec_i.flips[sbfc_pkg::FLIP_D] ? rec_i.off_y : rec_i.off_x;
    sy   = rec_i.flips[sbfc_pkg::FLIP_D] ? rec_i.off_x : rec_i.off_y;
    dx   = rec_i.flips[sbfc_pkg::FLIP_H] ? (rec_i.size_w - sx - 10'd1) : sx;
    dy   = rec_i.flips[sbfc_pkg::FLIP_V] ? (rec_i.size_h - sy - 10'd1) : sy;
    // flipped offsets wrap below zero, so extend by sign of the wrap
    px_d = 24'(rec_i.base_col) + (rec_i.flips[sbfc_pkg::FLIP_H] && (sx >= rec_i.size_w) ?
           {14'h3fff, dx} : {14'h0000, dx});
    py_d = 24'(rec_i.base_row) + (rec_i.flips[sbfc_pkg::FLIP_V] && (sy >= rec_i.size_h) ?
           {14'h3fff, dy} : {14'h0000, dy});
  end

  assign prod   = 36'(a_stride_q) * 36'(a_py_q);
  assign addr_d = prod[23:0] + a_px_q;
  assign fidx_d = 20'(a_cy_q) * 20'(SCREEN_WIDTH) + 20'(a_cx_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_px_q     <= px_d;
      a_py_q     <= py_d;
      a_stride_q <= rec_i.stride;
      a_fetch_q  <= rec_i.has_fetch;
      a_on_q     <= rec_i.on;
      a_cx_q     <= rec_i.cx;
      a_cy_q     <= rec_i.cy;
      a_color_q  <= rec_i.color;
      a_wr_q     <= rec_i.wr;
      a_done_q   <= rec_i.done;
    end
    if (a_v_q && out_ready) begin
      out_addr_q  <= a_fetch_q ? addr_d : '0;
      out_fidx_q  <= a_on_q ? fidx_d[16:0] : '0;
      out_color_q <= a_color_q;
      out_wr_q    <= a_wr_q;
      out_done_q  <= a_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= valid_i;
      end
      if (out_ready) begin
        out_v_q <= a_v_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_color_q, out_fidx_q, out_addr_q};
  assign m_axis_tuser  = out_wr_q;
  assign m_axis_tlast  = out_done_q;

endmodule

/* rtl/core/sprite_blit_flip_colorkey.sv */
// top level of the sprite blitter with flip and color key
// one word in and one word out per cycle sustained while the output is not stalled
// result is registered through the queue, the address stage and the output register
// a two-entry queue lets the walk front run ahead of a stalled output
// reset clears the walk state and blit registers, empties the pipeline, block idle
`timescale 1ns / 1ps
module sprite_blit_flip_colorkey #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // place_x, place_y, sprite_w, sprite_h, sheet_col, sheet_row, sheet_stride,
  // flip_mask, key_color, sheet_pixel
  input  logic [sbfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fetch_addr, frame_index, write_color
  output logic [sbfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // write_en
  output logic                            m_axis_tuser,
  // blit_done
  output logic                            m_axis_tlast
);

  sbfc_pkg::sbfc_rec_t push_rec, pop_rec;
  logic                push, pop, full, q_valid;

  sbfc_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .full_i       (full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  sbfc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_rec),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .data_o (pop_rec)
  );

  sbfc_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .rec_i        (pop_rec),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
